### rtl/core/pfkp_pkg.sv
// ----------------------------------------------------------------------------
// pfkp_pkg
// shared types and constants of the packet flow key parser
// ----------------------------------------------------------------------------
package pfkp_pkg;

  localparam int MAX_VLAN_TAGS_DEF = 2;

  localparam int ETH_TYPE_OFFSET = 12;
  localparam int VLAN_TAG_BYTES  = 4;
  localparam int IPV6_HDR_BYTES  = 40;

  localparam logic [15:0] ET_IPV4 = 16'h0800;
  localparam logic [15:0] ET_IPV6 = 16'h86DD;
  localparam logic [15:0] ET_ARP  = 16'h0806;
  localparam logic [15:0] ET_LLDP = 16'h88CC;
  localparam logic [15:0] ET_VLAN = 16'h8100;

  localparam logic [7:0] PR_ICMP  = 8'd1;
  localparam logic [7:0] PR_IGMP  = 8'd2;
  localparam logic [7:0] PR_TCP   = 8'd6;
  localparam logic [7:0] PR_UDP   = 8'd17;
  localparam logic [7:0] PR_ICMP6 = 8'd58;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_ARP         = 4'd1,
    ST_LLDP        = 4'd2,
    ST_OTHER_TYPE  = 4'd3,
    ST_UNK_PROTO   = 4'd4,
    ST_BAD_HLEN    = 4'd5,
    ST_BAD_TCP_OFF = 4'd6,
    ST_TRUNC       = 4'd7,
    ST_TAGS        = 4'd8
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] ethertype;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [7:0]  protocol;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] length;
  } result_t;

endpackage

### rtl/core/pfkp_parse_core.sv
// ----------------------------------------------------------------------------
// pfkp_parse_core
// per-frame header state, one byte per step, flow key result on the last byte
// ----------------------------------------------------------------------------
module pfkp_parse_core #(
  parameter int MAX_VLAN_TAGS = pfkp_pkg::MAX_VLAN_TAGS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic [15:0]       frame_length_i,
  output pfkp_pkg::result_t result_o
);
  import pfkp_pkg::*;

  localparam int TagW = $clog2(MAX_VLAN_TAGS + 1);
  localparam int OffW = $clog2(ETH_TYPE_OFFSET + VLAN_TAG_BYTES * MAX_VLAN_TAGS + 3);

  logic [7:0]      pos_q, pos_d;
  logic [OffW-1:0] type_off_q, type_off_d;
  logic [TagW-1:0] tag_cnt_q, tag_cnt_d;
  logic [OffW-1:0] l3_start_q, l3_start_d;
  logic [7:0]      l4_start_q, l4_start_d;
  logic [15:0]     etype_q, etype_d;
  logic [7:0]      proto_q, proto_d;
  logic [63:0]     src_hi_q, src_hi_d, src_lo_q, src_lo_d;
  logic [63:0]     dst_hi_q, dst_hi_d, dst_lo_q, dst_lo_d;
  logic [15:0]     sport_q, sport_d, dport_q, dport_d;
  status_e         status_q, status_d;
  logic            decided_q, decided_d;
  logic [15:0]     len_q, len_d;

  logic [7:0]      b;
  logic [15:0]     etype_new;
  logic [7:0]      rel3, rel4;
  logic [7:0]      l3_ext;
  logic            ok;
  result_t         res;

  assign b      = data_byte_i;
  assign l3_ext = 8'(l3_start_q);
  assign rel3   = pos_q - l3_ext;
  assign rel4   = pos_q - l4_start_q;

  always_comb begin
    pos_d      = pos_q;
    type_off_d = type_off_q;
    tag_cnt_d  = tag_cnt_q;
    l3_start_d = l3_start_q;
    l4_start_d = l4_start_q;
    etype_d    = etype_q;
    proto_d    = proto_q;
    src_hi_d   = src_hi_q;
    src_lo_d   = src_lo_q;
    dst_hi_d   = dst_hi_q;
    dst_lo_d   = dst_lo_q;
    sport_d    = sport_q;
    dport_d    = dport_q;
    status_d   = status_q;
    decided_d  = decided_q;
    len_d      = len_q;
    etype_new  = etype_q | {8'h00, b};

    if (pos_q == 8'd0) begin
      len_d = frame_length_i;
    end

    if (!decided_q) begin
      if (l3_start_q == '0) begin
        if (pos_q == 8'(type_off_q)) begin
          etype_d = {b, 8'h00};
        end else if (pos_q == 8'(type_off_q) + 8'd1) begin
          etype_d = etype_new;
          if (etype_new == ET_VLAN) begin
            if (tag_cnt_q >= TagW'(MAX_VLAN_TAGS)) begin
              status_d  = ST_TAGS;
              decided_d = 1'b1;
            end else begin
              tag_cnt_d  = tag_cnt_q + TagW'(1);
              type_off_d = type_off_q + OffW'(VLAN_TAG_BYTES);
            end
          end else begin
            l3_start_d = type_off_q + OffW'(2);
            if (etype_new == ET_IPV6) begin
              l4_start_d = 8'(type_off_q + OffW'(2)) + 8'(IPV6_HDR_BYTES);
            end else if (etype_new != ET_IPV4) begin
              decided_d = 1'b1;
              if (etype_new == ET_ARP) begin
                status_d = ST_ARP;
              end else if (etype_new == ET_LLDP) begin
                status_d = ST_LLDP;
              end else begin
                status_d = ST_OTHER_TYPE;
              end
            end
          end
        end
      end else if (pos_q >= l3_ext) begin
        if (etype_q == ET_IPV4) begin
          if (rel3 == 8'd0) begin
            if (b[3:0] < 4'd5) begin
              status_d  = ST_BAD_HLEN;
              decided_d = 1'b1;
            end else begin
              l4_start_d = l3_ext + {2'b00, b[3:0], 2'b00};
            end
          end else if (rel3 == 8'd9) begin
            proto_d = b;
            if (!(b inside {PR_ICMP, PR_IGMP, PR_TCP, PR_UDP})) begin
              status_d  = ST_UNK_PROTO;
              decided_d = 1'b1;
            end
          end else if (rel3 >= 8'd12 && rel3 <= 8'd15) begin
            src_lo_d = {32'h0, src_lo_q[23:0], b};
          end else if (rel3 >= 8'd16 && rel3 <= 8'd19) begin
            dst_lo_d = {32'h0, dst_lo_q[23:0], b};
            if (rel3 == 8'd19 && (proto_q inside {PR_ICMP, PR_IGMP})) begin
              status_d  = ST_OK;
              decided_d = 1'b1;
            end
          end
        end else begin
          if (rel3 == 8'd6) begin
            proto_d = b;
            if (!(b inside {PR_ICMP, PR_IGMP, PR_TCP, PR_UDP, PR_ICMP6})) begin
              status_d  = ST_UNK_PROTO;
              decided_d = 1'b1;
            end
          end else if (rel3 >= 8'd8 && rel3 <= 8'd15) begin
            src_hi_d = {src_hi_q[55:0], b};
          end else if (rel3 >= 8'd16 && rel3 <= 8'd23) begin
            src_lo_d = {src_lo_q[55:0], b};
          end else if (rel3 >= 8'd24 && rel3 <= 8'd31) begin
            dst_hi_d = {dst_hi_q[55:0], b};
          end else if (rel3 >= 8'd32 && rel3 <= 8'd39) begin
            dst_lo_d = {dst_lo_q[55:0], b};
            if (rel3 == 8'd39 && (proto_q inside {PR_ICMP, PR_IGMP, PR_ICMP6})) begin
              status_d  = ST_OK;
              decided_d = 1'b1;
            end
          end
        end

        // transport header, never on a byte where the ip header decides
        if (l4_start_q != 8'd0 && pos_q >= l4_start_q) begin
          if (rel4 < 8'd2) begin
            sport_d = {sport_q[7:0], b};
          end else if (rel4 < 8'd4) begin
            dport_d = {dport_q[7:0], b};
          end
          if (rel4 == 8'd3 && proto_q == PR_UDP) begin
            status_d  = ST_OK;
            decided_d = 1'b1;
          end
          if (rel4 == 8'd12 && proto_q == PR_TCP) begin
            status_d  = (b[7:4] < 4'd5) ? ST_BAD_TCP_OFF : ST_OK;
            decided_d = 1'b1;
          end
        end
      end
    end

    if (pos_q != 8'hFF) begin
      pos_d = pos_q + 8'd1;
    end

    ok            = decided_d && (status_d == ST_OK);
    res.status    = decided_d ? status_d : ST_TRUNC;
    res.ethertype = etype_d;
    res.src_hi    = ok ? src_hi_d : 64'h0;
    res.src_lo    = ok ? src_lo_d : 64'h0;
    res.dst_hi    = ok ? dst_hi_d : 64'h0;
    res.dst_lo    = ok ? dst_lo_d : 64'h0;
    res.protocol  = proto_d;
    res.sport     = ok ? sport_d : 16'h0;
    res.dport     = ok ? dport_d : 16'h0;
    res.length    = len_d;

    if (last_byte_i) begin
      pos_d      = 8'd0;
      type_off_d = OffW'(ETH_TYPE_OFFSET);
      tag_cnt_d  = '0;
      l3_start_d = '0;
      l4_start_d = 8'd0;
      etype_d    = 16'h0;
      proto_d    = 8'h0;
      src_hi_d   = 64'h0;
      src_lo_d   = 64'h0;
      dst_hi_d   = 64'h0;
      dst_lo_d   = 64'h0;
      sport_d    = 16'h0;
      dport_d    = 16'h0;
      status_d   = ST_TRUNC;
      decided_d  = 1'b0;
      len_d      = 16'h0;
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 8'd0;
      type_off_q <= OffW'(ETH_TYPE_OFFSET);
      tag_cnt_q  <= '0;
      l3_start_q <= '0;
      l4_start_q <= 8'd0;
      etype_q    <= 16'h0;
      proto_q    <= 8'h0;
      src_hi_q   <= 64'h0;
      src_lo_q   <= 64'h0;
      dst_hi_q   <= 64'h0;
      dst_lo_q   <= 64'h0;
      sport_q    <= 16'h0;
      dport_q    <= 16'h0;
      status_q   <= ST_TRUNC;
      decided_q  <= 1'b0;
      len_q      <= 16'h0;
    end else if (step_i) begin
      pos_q      <= pos_d;
      type_off_q <= type_off_d;
      tag_cnt_q  <= tag_cnt_d;
      l3_start_q <= l3_start_d;
      l4_start_q <= l4_start_d;
      etype_q    <= etype_d;
      proto_q    <= proto_d;
      src_hi_q   <= src_hi_d;
      src_lo_q   <= src_lo_d;
      dst_hi_q   <= dst_hi_d;
      dst_lo_q   <= dst_lo_d;
      sport_q    <= sport_d;
      dport_q    <= dport_d;
      status_q   <= status_d;
      decided_q  <= decided_d;
      len_q      <= len_d;
    end
  end

`ifndef SYNTHESIS
  a_tag_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_cnt_q <= TagW'(MAX_VLAN_TAGS))
    else $error("vlan tag count above limit");

  a_undecided_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decided_q == (status_q != ST_TRUNC))
    else $error("status and decision flag disagree");

  a_l3_is_ip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (l3_start_q != '0 && !decided_q) |-> (etype_q == ET_IPV4 || etype_q == ET_IPV6))
    else $error("undecided non-ip frame past ethertype");
`endif

endmodule

### rtl/core/packet_flow_key_parser.sv
// ----------------------------------------------------------------------------
// packet_flow_key_parser
// ethernet/ip flow key parser: addresses, protocol and ports per frame
// ----------------------------------------------------------------------------
// Frames enter one byte per cycle in wire order; a byte is taken in every
// cycle in which the result register is empty or being drained. On the byte
// marked last, the flow key (status, ethertype, addresses, protocol, ports
// and wire length) is loaded into the result register and is offered on the
// next cycle; throughput is one byte per cycle while in_ready_o is high.
// Up to MAX_VLAN_TAGS 802.1Q tags are skipped; a further tag gives the
// too-many-tags status. Any non-ok status zeroes addresses and ports.
// ----------------------------------------------------------------------------
module packet_flow_key_parser #(
  parameter int MAX_VLAN_TAGS = pfkp_pkg::MAX_VLAN_TAGS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] frame_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic [15:0] ethertype_o,
  output logic [63:0] src_addr_hi_o,
  output logic [63:0] src_addr_lo_o,
  output logic [63:0] dst_addr_hi_o,
  output logic [63:0] dst_addr_lo_o,
  output logic [7:0]  l4_protocol_o,
  output logic [15:0] src_port_o,
  output logic [15:0] dst_port_o,
  output logic [15:0] wire_length_o
);
  import pfkp_pkg::*;

  logic    in_fire;
  logic    out_valid_q, out_valid_d;
  result_t core_res;
  result_t res_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  pfkp_parse_core #(
    .MAX_VLAN_TAGS(MAX_VLAN_TAGS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_fire),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .frame_length_i(frame_length_i),
    .result_o      (core_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && last_byte_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_byte_i) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign ethertype_o   = res_q.ethertype;
  assign src_addr_hi_o = res_q.src_hi;
  assign src_addr_lo_o = res_q.src_lo;
  assign dst_addr_hi_o = res_q.dst_hi;
  assign dst_addr_lo_o = res_q.dst_lo;
  assign l4_protocol_o = res_q.protocol;
  assign src_port_o    = res_q.sport;
  assign dst_port_o    = res_q.dport;
  assign wire_length_o = res_q.length;

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_byte_i) |=> out_valid_o)
    else $error("last byte without result transaction");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  a_fail_zeroes_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (src_port_o == 16'h0 && dst_port_o == 16'h0 &&
       src_addr_lo_o == 64'h0 && dst_addr_lo_o == 64'h0))
    else $error("flow key not cleared on failed frame");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_TAGS))
    else $error("status code out of range");
`endif

endmodule
